/* hw/rtl/tbeq_pkg.sv */
// Shared widths, register indexes and operand types for the three-band equalizer.
// No dependencies; every module of the block imports this package.
package tbeq_pkg;

    // Sample and pole formats.
    localparam int SAMPLE_WIDTH   = 24;
    localparam int POLE_FRAC_BITS = 8;
    localparam int POLE_WIDTH     = SAMPLE_WIDTH + POLE_FRAC_BITS;
    localparam int STAGES         = 4;
    localparam int HIST_DEPTH     = 3;

    // Coefficient and gain formats.
    localparam int COEFF_WIDTH = 18;
    localparam int COEFF_FRAC  = 16;
    localparam int GAIN_WIDTH  = 16;
    localparam int GAIN_FRAC   = 12;

    // Shared multiplier operands: bands need two bits above the pole width.
    localparam int OPA_WIDTH  = POLE_WIDTH + 2;
    localparam int OPB_WIDTH  = COEFF_WIDTH + 1;
    localparam int PROD_WIDTH = OPA_WIDTH + OPB_WIDTH;

    // Configuration port.
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = COEFF_WIDTH;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOW_COEFF  = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HIGH_COEFF = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOW_GAIN   = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MID_GAIN   = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HIGH_GAIN  = 3'd4;

    typedef logic signed [OPA_WIDTH-1:0]  opa_t;
    typedef logic signed [OPB_WIDTH-1:0]  opb_t;
    typedef logic signed [PROD_WIDTH-1:0] prod_t;

endpackage

/* hw/rtl/tbeq_mul.sv */
// Registered signed multiplier shared by the filter stages and the band gains.
// Depends on tbeq_pkg for the operand and product types.
module tbeq_mul
    import tbeq_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  opa_t  opa,
    input  opb_t  opb,
    output prod_t prod
);

    prod_t prod_reg;

    // Product is captured only when the sequencer issues a multiply.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_t'(opa) * prod_t'(opb);
        end
    end

    assign prod = prod_reg;

endmodule

/* hw/rtl/three_band_equalizer_core.sv */
// Three-band equalizer core: sequencer, pole and history storage, configuration.
// Depends on tbeq_pkg and the shared multiplier tbeq_mul.
//
// Usage:
//   Input channel: in_valid / in_stall with sample_in. A transaction is taken
//   when in_valid is high and in_stall is low; in_stall is high while a sample
//   is being processed. Output channel: out_valid / out_stall with sample_out,
//   held in an output register until the receiver takes the transaction.
//   Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high. Write only while the core is idle. Unknown indexes are ignored.
//   Processing: each enabled cascade stage takes operand setup, multiply and
//   pole update on one shared multiplier; after both cascades the core forms
//   the bands, then does the three gain products and the final rounding. A
//   gated cascade is passed over in its setup step. A new sample is taken
//   only after the previous result has been written to the output register.
//   Reset: poles and sample history clear to zero, coefficients to zero and
//   gains to 1.0. If the receiver stalls, the finished result waits in the
//   output register; a following result waits in its last step until it is free.
module three_band_equalizer_core
    import tbeq_pkg::*;
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]    sample_in,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]    sample_out,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic        [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic        [CFG_DATA_WIDTH-1:0]  cfg_data
);

    localparam int STAGE_IDX_WIDTH = $clog2(STAGES);
    localparam int POLE_IDX_WIDTH  = STAGE_IDX_WIDTH + 1;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SETUP  = 4'd1;
    localparam logic [3:0] ST_MUL    = 4'd2;
    localparam logic [3:0] ST_UPD    = 4'd3;
    localparam logic [3:0] ST_BANDS  = 4'd4;
    localparam logic [3:0] ST_GSETUP = 4'd5;
    localparam logic [3:0] ST_GMUL   = 4'd6;
    localparam logic [3:0] ST_GACC   = 4'd7;
    localparam logic [3:0] ST_FIN    = 4'd8;

    // Gain step selection.
    localparam logic [1:0] GSEL_LOW  = 2'd0;
    localparam logic [1:0] GSEL_MID  = 2'd1;
    localparam logic [1:0] GSEL_HIGH = 2'd2;

    localparam logic [STAGE_IDX_WIDTH-1:0] LAST_STAGE = STAGE_IDX_WIDTH'(STAGES - 1);

    // Rounding offsets; the pole-scale offset is zero when there are no extra bits.
    localparam prod_t ROUND_COEFF = prod_t'(1) <<< (COEFF_FRAC - 1);
    localparam prod_t ROUND_GAIN  = prod_t'(1) <<< (GAIN_FRAC - 1);
    localparam prod_t ROUND_POLE  = prod_t'((1 << POLE_FRAC_BITS) >> 1);

    localparam logic signed [POLE_WIDTH-1:0] POLE_MAX = {1'b0, {(POLE_WIDTH-1){1'b1}}};
    localparam logic signed [POLE_WIDTH-1:0] POLE_MIN = {1'b1, {(POLE_WIDTH-1){1'b0}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // Saturate a product-width value to the pole width.
    function automatic logic signed [POLE_WIDTH-1:0] sat_pole(input prod_t v);
        logic [PROD_WIDTH-POLE_WIDTH:0] upper;
        upper = v[PROD_WIDTH-1:POLE_WIDTH-1];
        if ((&upper) || !(|upper))
            return v[POLE_WIDTH-1:0];
        else if (v[PROD_WIDTH-1])
            return POLE_MIN;
        else
            return POLE_MAX;
    endfunction

    // Saturate a product-width value to the sample width.
    function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(input prod_t v);
        logic [PROD_WIDTH-SAMPLE_WIDTH:0] upper;
        upper = v[PROD_WIDTH-1:SAMPLE_WIDTH-1];
        if ((&upper) || !(|upper))
            return v[SAMPLE_WIDTH-1:0];
        else if (v[PROD_WIDTH-1])
            return SAMPLE_MIN;
        else
            return SAMPLE_MAX;
    endfunction

    // Configuration registers.
    logic        [COEFF_WIDTH-1:0] low_coeff_reg;
    logic        [COEFF_WIDTH-1:0] high_coeff_reg;
    logic signed [GAIN_WIDTH-1:0]  low_gain_reg;
    logic signed [GAIN_WIDTH-1:0]  mid_gain_reg;
    logic signed [GAIN_WIDTH-1:0]  high_gain_reg;

    // Control registers.
    logic [3:0]                 state_reg, state_next;
    logic [STAGE_IDX_WIDTH-1:0] stage_reg, stage_next;
    logic                       band_reg, band_next;
    logic [1:0]                 gsel_reg, gsel_next;
    logic                       out_valid_reg, out_valid_next;

    // Datapath registers.
    logic signed [SAMPLE_WIDTH-1:0] sample_reg, sample_next;
    logic signed [POLE_WIDTH-1:0]   x_reg, x_next;
    opa_t                           opa_reg, opa_next;
    opb_t                           opb_reg, opb_next;
    prod_t                          acc_reg, acc_next;
    opa_t                           lband_reg, lband_next;
    opa_t                           mband_reg, mband_next;
    opa_t                           hband_reg, hband_next;
    logic signed [SAMPLE_WIDTH-1:0] out_data_reg, out_data_next;
    logic signed [SAMPLE_WIDTH-1:0] hist_reg [HIST_DEPTH];
    logic signed [POLE_WIDTH-1:0]   poles_reg [2*STAGES];

    // Combinational datapath signals.
    logic                           hist_shift;
    logic                           pole_we;
    logic [POLE_IDX_WIDTH-1:0]      pole_idx;
    logic signed [POLE_WIDTH-1:0]   pole_cur;
    logic signed [POLE_WIDTH-1:0]   new_pole;
    logic signed [POLE_WIDTH-1:0]   x_start;
    logic signed [POLE_WIDTH-1:0]   x_in;
    logic signed [POLE_WIDTH-1:0]   d3;
    prod_t                          prod;
    prod_t                          stage_sum;
    prod_t                          gain_term;
    prod_t                          final_round;
    logic signed [SAMPLE_WIDTH-1:0] result;
    logic                           en_low;
    logic                           en_high;
    logic                           band_en;
    logic                           mul_en;
    opa_t                           band_l;
    opa_t                           band_h;

    tbeq_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .opa  (opa_reg),
        .opb  (opb_reg),
        .prod (prod)
    );

    // Handshake outputs.
    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign sample_out = out_data_reg;
    assign cfg_ready  = 1'b1;

    // A cascade runs unless both its own gain and the mid gain are zero.
    assign en_low  = (low_gain_reg != '0) || (mid_gain_reg != '0);
    assign en_high = (high_gain_reg != '0) || (mid_gain_reg != '0);
    assign band_en = band_reg ? en_high : en_low;

    // Pole arithmetic for the current stage.
    assign pole_idx  = {band_reg, stage_reg};
    assign pole_cur  = poles_reg[pole_idx];
    assign stage_sum = prod_t'(pole_cur) + ((prod + ROUND_COEFF) >>> COEFF_FRAC);
    assign new_pole  = sat_pole(stage_sum);

    // Samples moved to pole scale.
    assign x_in    = POLE_WIDTH'(sample_in) <<< POLE_FRAC_BITS;
    assign x_start = POLE_WIDTH'(sample_reg) <<< POLE_FRAC_BITS;
    assign d3      = POLE_WIDTH'(hist_reg[HIST_DEPTH-1]) <<< POLE_FRAC_BITS;

    // Gain product rounding and final output rounding.
    assign gain_term   = (prod + ROUND_GAIN) >>> GAIN_FRAC;
    assign final_round = (acc_reg + ROUND_POLE) >>> POLE_FRAC_BITS;
    assign result      = sat_sample(final_round);

    // Band values from the last stage of each cascade.
    assign band_l = en_low ? opa_t'(poles_reg[STAGES-1]) : '0;
    assign band_h = en_high ? (opa_t'(d3) - opa_t'(poles_reg[2*STAGES-1])) : '0;

    assign mul_en = (state_reg == ST_MUL) || (state_reg == ST_GMUL);

    // Sequencer and next-value logic.
    always_comb
    begin
        state_next     = state_reg;
        stage_next     = stage_reg;
        band_next      = band_reg;
        gsel_next      = gsel_reg;
        sample_next    = sample_reg;
        x_next         = x_reg;
        opa_next       = opa_reg;
        opb_next       = opb_reg;
        acc_next       = acc_reg;
        lband_next     = lband_reg;
        mband_next     = mband_reg;
        hband_next     = hband_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        hist_shift     = 1'b0;
        pole_we        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    sample_next = sample_in;
                    x_next      = x_in;
                    band_next   = 1'b0;
                    stage_next  = '0;
                    state_next  = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (!band_en)
                begin
                    if (!band_reg)
                    begin
                        band_next = 1'b1;
                        x_next    = x_start;
                    end
                    else
                    begin
                        state_next = ST_BANDS;
                    end
                end
                else
                begin
                    opa_next   = opa_t'(x_reg) - opa_t'(pole_cur);
                    opb_next   = band_reg ? opb_t'({1'b0, high_coeff_reg})
                                          : opb_t'({1'b0, low_coeff_reg});
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                pole_we = 1'b1;
                x_next  = new_pole;
                if (stage_reg == LAST_STAGE)
                begin
                    stage_next = '0;
                    if (!band_reg)
                    begin
                        band_next  = 1'b1;
                        x_next     = x_start;
                        state_next = ST_SETUP;
                    end
                    else
                    begin
                        state_next = ST_BANDS;
                    end
                end
                else
                begin
                    stage_next = stage_reg + 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_BANDS:
            begin
                lband_next = band_l;
                hband_next = band_h;
                mband_next = opa_t'(d3) - band_h - band_l;
                acc_next   = '0;
                gsel_next  = GSEL_LOW;
                state_next = ST_GSETUP;
            end
            ST_GSETUP:
            begin
                case (gsel_reg)
                    GSEL_LOW:
                    begin
                        opa_next = lband_reg;
                        opb_next = opb_t'(low_gain_reg);
                    end
                    GSEL_MID:
                    begin
                        opa_next = mband_reg;
                        opb_next = opb_t'(mid_gain_reg);
                    end
                    default:
                    begin
                        opa_next = hband_reg;
                        opb_next = opb_t'(high_gain_reg);
                    end
                endcase
                state_next = ST_GMUL;
            end
            ST_GMUL:
            begin
                state_next = ST_GACC;
            end
            ST_GACC:
            begin
                acc_next = acc_reg + gain_term;
                if (gsel_reg == GSEL_HIGH)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    gsel_next  = gsel_reg + 1'b1;
                    state_next = ST_GSETUP;
                end
            end
            ST_FIN:
            begin
                // Wait here while an earlier result is still held by the receiver.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = result;
                    hist_shift     = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            stage_reg      <= '0;
            band_reg       <= 1'b0;
            gsel_reg       <= GSEL_LOW;
            out_valid_reg  <= 1'b0;
            low_coeff_reg  <= '0;
            high_coeff_reg <= '0;
            low_gain_reg   <= GAIN_WIDTH'(1 << GAIN_FRAC);
            mid_gain_reg   <= GAIN_WIDTH'(1 << GAIN_FRAC);
            high_gain_reg  <= GAIN_WIDTH'(1 << GAIN_FRAC);
        end
        else
        begin
            state_reg     <= state_next;
            stage_reg     <= stage_next;
            band_reg      <= band_next;
            gsel_reg      <= gsel_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LOW_COEFF:  low_coeff_reg  <= cfg_data[COEFF_WIDTH-1:0];
                    REG_HIGH_COEFF: high_coeff_reg <= cfg_data[COEFF_WIDTH-1:0];
                    REG_LOW_GAIN:   low_gain_reg   <= cfg_data[GAIN_WIDTH-1:0];
                    REG_MID_GAIN:   mid_gain_reg   <= cfg_data[GAIN_WIDTH-1:0];
                    REG_HIGH_GAIN:  high_gain_reg  <= cfg_data[GAIN_WIDTH-1:0];
                    default:        ;
                endcase
            end
        end
    end

    // Filter state: poles and sample history clear at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2*STAGES; i++)
            begin
                poles_reg[i] <= '0;
            end
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            if (pole_we)
            begin
                poles_reg[pole_idx] <= new_pole;
            end
            if (hist_shift)
            begin
                for (int i = HIST_DEPTH - 1; i > 0; i--)
                begin
                    hist_reg[i] <= hist_reg[i-1];
                end
                hist_reg[0] <= sample_reg;
            end
        end
    end

    // Datapath payload registers.
    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        x_reg        <= x_next;
        opa_reg      <= opa_next;
        opb_reg      <= opb_next;
        acc_reg      <= acc_next;
        lband_reg    <= lband_next;
        mband_reg    <= mband_next;
        hband_reg    <= hband_next;
        out_data_reg <= out_data_next;
    end

    // A pole update always follows the multiply that produced its product.
    a_upd_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD) |-> ($past(state_reg) == ST_MUL))
        else $error("pole update without a preceding multiply");

    // The stage counter is nonzero only inside a cascade pass.
    a_stage_in_cascade: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_reg != '0) |->
            ((state_reg == ST_SETUP) || (state_reg == ST_MUL) || (state_reg == ST_UPD)))
        else $error("stage counter left nonzero outside a cascade");

    // Finishing with a free output register publishes a result and returns to idle.
    a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FIN) && !(out_valid_reg && out_stall)) |=>
            (out_valid_reg && (state_reg == ST_IDLE)))
        else $error("finished sample not delivered");

    // An accepted sample starts the sequencer at its setup step.
    a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_SETUP))
        else $error("accepted transaction did not start the sequencer");

    // The gain step index never passes the high band.
    a_gsel_range: assert property (@(posedge clk) disable iff (!rst_n)
        (gsel_reg == GSEL_LOW) || (gsel_reg == GSEL_MID) || (gsel_reg == GSEL_HIGH))
        else $error("gain step index out of range");

endmodule
